### hdl/assert_macros.svh
// Assertion macros shared by the encoder RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication under reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### hdl/u8enc_pkg.sv
// Types, constants and helper functions for the UTF-8 encoder.
// No dependencies; used by every encoder module.
package u8enc_pkg;

	localparam int U8ENC_CP_W        = 32;
	localparam int U8ENC_QUEUE_DEPTH = 4;

	// Sequence length markers for the lead byte
	localparam logic [7:0] LEAD_MARK_1 = 8'h00;
	localparam logic [7:0] LEAD_MARK_2 = 8'hC0;
	localparam logic [7:0] LEAD_MARK_3 = 8'hE0;
	localparam logic [7:0] LEAD_MARK_4 = 8'hF0;
	localparam logic [7:0] LEAD_MARK_5 = 8'hF8;
	localparam logic [7:0] LEAD_MARK_6 = 8'hFC;
	localparam logic [7:0] CONT_MARK   = 8'h80;

	// Index of the last byte (sequence length minus one)
	localparam logic [2:0] NLAST_1 = 3'd0;
	localparam logic [2:0] NLAST_2 = 3'd1;
	localparam logic [2:0] NLAST_3 = 3'd2;
	localparam logic [2:0] NLAST_4 = 3'd3;
	localparam logic [2:0] NLAST_5 = 3'd4;
	localparam logic [2:0] NLAST_6 = 3'd5;

	// One classified code point, as queued between front and back
	typedef struct packed {
		logic        bad;    // code point at or above 2^31
		logic [2:0]  nlast;  // index of the final byte
		logic [30:0] cp;     // low 31 bits of the code point
	} u8enc_item_t;

	// Queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} u8enc_qstat_t;

	function automatic logic [7:0] lead_mark(input logic [2:0] nlast);
		logic [7:0] m;
		case (nlast)
			NLAST_1: m = LEAD_MARK_1;
			NLAST_2: m = LEAD_MARK_2;
			NLAST_3: m = LEAD_MARK_3;
			NLAST_4: m = LEAD_MARK_4;
			NLAST_5: m = LEAD_MARK_5;
			NLAST_6: m = LEAD_MARK_6;
			default: m = LEAD_MARK_1;
		endcase
		return m;
	endfunction

endpackage

### hdl/u8enc_front.sv
// Front end: takes a code point and classifies its sequence length.
// Depends on u8enc_pkg.
module u8enc_front
	import u8enc_pkg::*;
(
	input  logic                  start,
	input  logic [U8ENC_CP_W-1:0] code_point,
	input  u8enc_qstat_t          qstat,
	output logic                  busy,
	output logic                  push,
	output u8enc_item_t           item
);

	// Hold off new commands while the queue has no room
	assign busy = qstat.full;
	assign push = start & ~qstat.full;

	// Length from the highest set bit group; shortest form always
	always_comb begin
		item.bad = code_point[31];
		item.cp  = code_point[30:0];
		if (code_point[31]) begin
			item.nlast = NLAST_1;
		end else if (|code_point[30:26]) begin
			item.nlast = NLAST_6;
		end else if (|code_point[25:21]) begin
			item.nlast = NLAST_5;
		end else if (|code_point[20:16]) begin
			item.nlast = NLAST_4;
		end else if (|code_point[15:11]) begin
			item.nlast = NLAST_3;
		end else if (|code_point[10:7]) begin
			item.nlast = NLAST_2;
		end else begin
			item.nlast = NLAST_1;
		end
	end

endmodule

### hdl/u8enc_queue.sv
// Small FIFO of classified code points between front and back end.
// Depends on u8enc_pkg; depth set by the DEPTH parameter (2 or more).
module u8enc_queue
	import u8enc_pkg::*;
#(
	parameter int DEPTH = U8ENC_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  u8enc_item_t  wr_item,
	input  logic         pop,
	output u8enc_item_t  rd_item,
	output u8enc_qstat_t qstat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	u8enc_item_t      entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == CNT_W'(DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rd_item     = entries_q[rd_ptr_q];

	// Storage, written on each push transfer
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/u8enc_back.sv
// Back end: serializes one queued code point into UTF-8 bytes, one per cycle.
// Depends on u8enc_pkg; results leave through registered outputs.
module u8enc_back
	import u8enc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  u8enc_item_t  head,
	input  u8enc_qstat_t qstat,
	output logic         pop,
	output logic         valid,
	output logic [7:0]   out_byte,
	output logic         last_byte,
	output logic         status
);

	u8enc_item_t cur_q;
	logic        cur_valid_q;
	logic [2:0]  rem_q;      // bytes still to go after the current one
	logic        valid_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic        status_q;
	logic [7:0]  grp;
	logic [7:0]  next_byte;
	logic        done_cur;

	// Take the next item when idle or on the final byte of the current one
	assign done_cur = ~cur_valid_q | (rem_q == '0);
	assign pop      = done_cur & ~qstat.empty;

	// Bit group selected by the remaining byte count: six bits, but seven for rem_q 0 and 1 and one for rem_q 5
	always_comb begin
		case (rem_q)
			3'd0:    grp = {1'b0, cur_q.cp[6:0]};
			3'd1:    grp = {1'b0, cur_q.cp[12:6]};
			3'd2:    grp = {2'b0, cur_q.cp[17:12]};
			3'd3:    grp = {2'b0, cur_q.cp[23:18]};
			3'd4:    grp = {2'b0, cur_q.cp[29:24]};
			3'd5:    grp = {7'b0, cur_q.cp[30]};
			default: grp = 8'h00;
		endcase
	end

	// Lead byte carries the length mark, the rest are continuation bytes; a bad item gives a zero byte
	always_comb begin
		if (cur_q.bad) begin
			next_byte = 8'h00;
		end else if (rem_q == cur_q.nlast) begin
			next_byte = lead_mark(cur_q.nlast) | grp;
		end else begin
			next_byte = CONT_MARK | {2'b00, grp[5:0]};
		end
	end

	// Current item and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			rem_q       <= '0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
			rem_q       <= head.nlast;
		end else if (cur_valid_q) begin
			if (rem_q == '0) begin
				cur_valid_q <= 1'b0;
			end else begin
				rem_q <= rem_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	// Output register: strobe under reset, payload free-running
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		byte_q   <= next_byte;
		last_q   <= (rem_q == '0);
		status_q <= cur_q.bad;
	end

	assign valid     = valid_q;
	assign out_byte  = byte_q;
	assign last_byte = last_q;
	assign status    = status_q;

endmodule

### hdl/utf8_code_point_encoder.sv
// Top level of the UTF-8 code point encoder (1-to-6-byte form).
// Depends on u8enc_pkg, u8enc_front, u8enc_queue, u8enc_back, assert_macros.svh.
//
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------
// command  | start, busy          | code_point[31:0]
// result   | valid (per byte)     | out_byte[7:0], last_byte, status
//
// A command transfers when start is high and busy is low; busy rises only
// when the QUEUE_DEPTH-entry queue is full. The serializer in the back end
// sends one byte per cycle, 1 to 6 bytes per code point (its sequence
// length; 1 for invalid input); a new command is taken every cycle while
// the queue has room, and waits there while the serializer is busy.
// Output bytes are registered. Reset empties the queue and the serializer.
`include "assert_macros.svh"

module utf8_code_point_encoder
	import u8enc_pkg::*;
#(
	parameter int QUEUE_DEPTH = U8ENC_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [U8ENC_CP_W-1:0] code_point,
	output logic                  valid,
	output logic [7:0]            out_byte,
	output logic                  last_byte,
	output logic                  status
);

	u8enc_item_t  wr_item;
	u8enc_item_t  head;
	u8enc_qstat_t qstat;
	logic         push;
	logic         pop;

	// Classify incoming code points
	u8enc_front u_front (
		.start      (start),
		.code_point (code_point),
		.qstat      (qstat),
		.busy       (busy),
		.push       (push),
		.item       (wr_item)
	);

	// Decoupling queue
	u8enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (head),
		.qstat   (qstat)
	);

	// Byte serializer
	u8enc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.valid     (valid),
		.out_byte  (out_byte),
		.last_byte (last_byte),
		.status    (status)
	);

	// Checks
	`ASSERT_IMPLY(a_bad_single, clk, arst_n, valid && status, last_byte && (out_byte == 8'h00), "invalid result must be a single zero byte")
	`ASSERT_NEXT(a_seq_contig, clk, arst_n, valid && !last_byte, valid, "byte sequence broken mid code point")
	`ASSERT_NEXT(a_push_lands, clk, arst_n, start && !busy, !qstat.empty, "accepted command missing from queue")
	`ASSERT_IMPLY(a_pop_nonempty, clk, arst_n, pop, !qstat.empty, "pop from empty queue")

endmodule

### bench/utf8_code_point_encoder_tb.sv
// Self-checking bench for utf8_code_point_encoder: directed table plus random code points,
// each byte checked against typed bytes or a behavioral encoder under varied sender idling.
// Depends on u8enc_pkg and the encoder RTL only.
module utf8_code_point_encoder_tb;
	import u8enc_pkg::*;

	localparam int CLK_HALF         = 5;
	localparam int CYCLE_LIMIT      = 20000;
	localparam int RANDOM_PER_PHASE = 42;
	localparam int DRAIN_CYCLES     = 12;

	// One expected output byte
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       bad;
	} enc_byte_t;

	// One stimulus row; n_bytes == 0 means the behavioral encoder supplies the bytes
	typedef struct packed {
		logic [31:0] cp;
		logic [2:0]  n_bytes;
		logic [47:0] bytes;    // lead byte in [47:40]
		logic        bad;
	} stim_row_t;

	// Magnitude classes of a code point, plus fully random values
	typedef enum int {
		CLS_1B, CLS_2B, CLS_3B, CLS_4B, CLS_5B, CLS_6B, CLS_BAD, CLS_ANY
	} cp_class_e;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic [U8ENC_CP_W-1:0] code_point = '0;
	stim_row_t             row_in_flight = '0;
	logic                  busy;
	logic                  valid;
	logic [7:0]            out_byte;
	logic                  last_byte;
	logic                  status;

	enc_byte_t expected_bytes[$];
	stim_row_t stim_table[$];
	int        sender_idle_pct[3] = '{21, 56, 0};
	int        idle_pct = 0;
	int        mismatches = 0;
	int        bytes_checked = 0;
	int        class_seen[0:6] = '{default: 0};
	int        cycle_count = 0;

	always #CLK_HALF clk = ~clk;

	utf8_code_point_encoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.code_point (code_point),
		.valid      (valid),
		.out_byte   (out_byte),
		.last_byte  (last_byte),
		.status     (status)
	);

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic cp_class_e classify(input logic [31:0] cp);
		if (cp < 32'h0000_0080) return CLS_1B;
		if (cp < 32'h0000_0800) return CLS_2B;
		if (cp < 32'h0001_0000) return CLS_3B;
		if (cp < 32'h0020_0000) return CLS_4B;
		if (cp < 32'h0400_0000) return CLS_5B;
		if (cp < 32'h8000_0000) return CLS_6B;
		return CLS_BAD;
	endfunction

	// Behavioral encoder: queues the byte sequence one code point produces
	function automatic void encode_code_point(input logic [31:0] cp);
		int         n;
		logic [7:0] mark;
		logic [31:0] shifted;
		enc_byte_t  r;
		r.bad = 1'b0;
		case (classify(cp))
			CLS_1B: begin n = 0; mark = LEAD_MARK_1; end
			CLS_2B: begin n = 1; mark = LEAD_MARK_2; end
			CLS_3B: begin n = 2; mark = LEAD_MARK_3; end
			CLS_4B: begin n = 3; mark = LEAD_MARK_4; end
			CLS_5B: begin n = 4; mark = LEAD_MARK_5; end
			CLS_6B: begin n = 5; mark = LEAD_MARK_6; end
			default: begin
				// out of range: a single zero byte flagged bad
				r.data = 8'h00;
				r.last = 1'b1;
				r.bad  = 1'b1;
				expected_bytes.push_back(r);
				return;
			end
		endcase
		for (int k = 0; k <= n; k++) begin
			shifted = cp >> (6 * (n - k));
			r.data  = (k == 0) ? (mark | shifted[7:0]) : (CONT_MARK | {2'b00, shifted[5:0]});
			r.last  = (k == n);
			expected_bytes.push_back(r);
		end
	endfunction

	// Queue the bytes typed into a table row
	function automatic void push_typed(input stim_row_t row);
		enc_byte_t r;
		for (int k = 0; k < int'(row.n_bytes); k++) begin
			r.data = row.bytes[47 - 8 * k -: 8];
			r.last = (k == int'(row.n_bytes) - 1);
			r.bad  = row.bad;
			expected_bytes.push_back(r);
		end
	endfunction

	function automatic void add_row(input logic [31:0] cp, input logic [2:0] n,
			input logic [47:0] b, input logic bad);
		stim_table.push_back('{cp, n, b, bad});
	endfunction

	function automatic stim_row_t random_row();
		cp_class_e   cls;
		logic [31:0] cp;
		cls = cp_class_e'($urandom_range(7, 0));
		case (cls)
			CLS_1B:  cp = $urandom_range(32'h0000_007F, 32'h0000_0000);
			CLS_2B:  cp = $urandom_range(32'h0000_07FF, 32'h0000_0080);
			CLS_3B:  cp = $urandom_range(32'h0000_FFFF, 32'h0000_0800);
			CLS_4B:  cp = $urandom_range(32'h001F_FFFF, 32'h0001_0000);
			CLS_5B:  cp = $urandom_range(32'h03FF_FFFF, 32'h0020_0000);
			CLS_6B:  cp = $urandom_range(32'h7FFF_FFFF, 32'h0400_0000);
			CLS_BAD: cp = 32'h8000_0000 | $urandom;
			default: cp = $urandom;
		endcase
		return '{cp, 3'd0, 48'h0, 1'b0};
	endfunction

	// Offer one code point, with an optional idle gap first, and wait for its transfer
	task automatic send_item(input stim_row_t row);
		if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		start         <= 1'b1;
		code_point    <= row.cp;
		row_in_flight <= row;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Record expectations on each command transfer; check each output byte
	always @(posedge clk) begin
		enc_byte_t exp_b;
		if (arst_n) begin
			if (start && busy === 1'b0) begin
				if (row_in_flight.n_bytes != 3'd0)
					push_typed(row_in_flight);
				else
					encode_code_point(code_point);
				class_seen[int'(classify(code_point))]++;
			end
			if (valid) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last %0b status %0b",
						out_byte, last_byte, status));
				end else begin
					exp_b = expected_bytes.pop_front();
					if (out_byte !== exp_b.data)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, exp_b.data));
					if (last_byte !== exp_b.last)
						report_mismatch($sformatf("last_byte %b, expected %b (byte %02h)",
							last_byte, exp_b.last, exp_b.data));
					if (status !== exp_b.bad)
						report_mismatch($sformatf("status %b, expected %b (byte %02h)",
							status, exp_b.bad, exp_b.data));
					bytes_checked++;
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d bytes outstanding",
				cycle_count, expected_bytes.size());
			$display("utf8_code_point_encoder_tb: FAIL");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: range boundaries, surrogates, beyond-Unicode and out-of-range values
		add_row(32'h0000_0000, 3'd1, 48'h0000_0000_0000, 1'b0);
		add_row(32'h0000_007F, 3'd1, 48'h7F00_0000_0000, 1'b0);
		add_row(32'h0000_0080, 3'd2, 48'hC280_0000_0000, 1'b0);
		add_row(32'h0000_07FF, 3'd2, 48'hDFBF_0000_0000, 1'b0);
		add_row(32'h0000_0800, 3'd3, 48'hE0A0_8000_0000, 1'b0);
		add_row(32'h0000_FFFF, 3'd3, 48'hEFBF_BF00_0000, 1'b0);
		add_row(32'h0000_D800, 3'd0, 48'h0, 1'b0);
		add_row(32'h0000_DFFF, 3'd0, 48'h0, 1'b0);
		add_row(32'h0001_0000, 3'd4, 48'hF090_8080_0000, 1'b0);
		add_row(32'h0010_FFFF, 3'd0, 48'h0, 1'b0);
		add_row(32'h0011_0000, 3'd0, 48'h0, 1'b0);
		add_row(32'h001F_FFFF, 3'd4, 48'hF7BF_BFBF_0000, 1'b0);
		add_row(32'h0020_0000, 3'd5, 48'hF888_8080_8000, 1'b0);
		add_row(32'h03FF_FFFF, 3'd5, 48'hFBBF_BFBF_BF00, 1'b0);
		add_row(32'h0400_0000, 3'd6, 48'hFC84_8080_8080, 1'b0);
		add_row(32'h7FFF_FFFF, 3'd6, 48'hFDBF_BFBF_BFBF, 1'b0);
		add_row(32'h8000_0000, 3'd1, 48'h0000_0000_0000, 1'b1);
		add_row(32'hFFFF_FFFF, 3'd1, 48'h0000_0000_0000, 1'b1);
		add_row(32'hAAAA_AAAA, 3'd0, 48'h0, 1'b0);
		add_row(32'h5555_5555, 3'd0, 48'h0, 1'b0);
		add_row(32'h0000_00E9, 3'd0, 48'h0, 1'b0);
		add_row(32'h0000_20AC, 3'd0, 48'h0, 1'b0);
		add_row(32'h0001_F600, 3'd0, 48'h0, 1'b0);

		idle_pct = sender_idle_pct[0];
		foreach (stim_table[i])
			send_item(stim_table[i]);

		// Random: sender idles often, then heavily, then never
		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = sender_idle_pct[phase];
			repeat (RANDOM_PER_PHASE) send_item(random_row());
		end
		start <= 1'b0;
		@(posedge clk);

		// Drain, then leave room for any stray trailing bytes
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("code points by length 1..6: %0d %0d %0d %0d %0d %0d, out of range: %0d",
			class_seen[0], class_seen[1], class_seen[2], class_seen[3],
			class_seen[4], class_seen[5], class_seen[6]);
		$display("%0d output bytes compared, %0d mismatches", bytes_checked, mismatches);
		if (mismatches == 0) begin
			$display("utf8_code_point_encoder_tb: PASS");
		end else begin
			$display("utf8_code_point_encoder_tb: FAIL");
		end
		$finish;
	end

endmodule
